// ===== hw/rtl/wildcard_glob_matcher_assert.svh =====
// Assertion macros used by the wildcard matcher top level.
`ifndef WILDCARD_GLOB_MATCHER_ASSERT_SVH
`define WILDCARD_GLOB_MATCHER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define WGM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wgm check failed: lbl");

// Next-cycle implication, checked out of reset.
`define WGM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wgm check failed: lbl");

`endif

// ===== hw/rtl/wgm_pkg.sv =====
// Package: types, codes and defaults for the wildcard matcher.
`timescale 1ns / 1ps

package wgm_pkg;

   localparam int MASK_DEPTH_DEF  = 64;
   localparam int QUEUE_DEPTH_DEF = 4;

   // Transaction action codes
   localparam logic [1:0] ACT_CLEAR   = 2'd0;
   localparam logic [1:0] ACT_APPEND  = 2'd1;
   localparam logic [1:0] ACT_SUBJECT = 2'd2;
   localparam logic [1:0] ACT_REPORT  = 2'd3;

   // Class of a byte as seen by the mask loader
   typedef enum logic [1:0] {
      CLS_PLAIN,
      CLS_STAR,
      CLS_QMARK,
      CLS_BSLASH
   } byte_class_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] byte_value;
   } wgm_req_type;

   typedef struct packed {
      logic matched;
      logic mask_overflow;
   } wgm_rsp_type;

   // Classified command passed from front to back
   typedef struct packed {
      logic [1:0]     action;
      logic           nonzero;
      byte_class_type cls;
      logic [7:0]     upper;
   } wgm_cmd_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } wgm_queue_status_type;

   typedef struct packed {
      logic mask_full;
      logic overflow;
   } wgm_back_status_type;

endpackage

// ===== hw/rtl/wgm_front.sv =====
// Front end: classify an incoming transaction for the matcher engine.
`timescale 1ns / 1ps

module wgm_front
   import wgm_pkg::*;
(
   input  wgm_req_type req,
   output wgm_cmd_type cmd
);

   logic [7:0] raw_byte;

   assign raw_byte = req.byte_value;

   always_comb begin
      cmd.action  = req.action;
      cmd.nonzero = (raw_byte != 8'h00);
      // fold lower-case ASCII letters onto upper case
      if (raw_byte inside {[8'h61 : 8'h7A]}) begin
         cmd.upper = raw_byte - 8'h20;
      end else begin
         cmd.upper = raw_byte;
      end
      case (raw_byte)
         8'h2A:   cmd.cls = CLS_STAR;
         8'h3F:   cmd.cls = CLS_QMARK;
         8'h5C:   cmd.cls = CLS_BSLASH;
         default: cmd.cls = CLS_PLAIN;
      endcase
   end

endmodule

// ===== hw/rtl/wgm_queue.sv =====
// Short command queue between the front end and the matcher engine.
`timescale 1ns / 1ps

module wgm_queue
   import wgm_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  wgm_cmd_type          push_cmd,
   input  logic                 pop,
   output wgm_cmd_type          head_cmd,
   output wgm_queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   wgm_cmd_type        entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] ptr);
      if (ptr == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return ptr + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_advance(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_advance(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd         = entry_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == CNT_W'(DEPTH));

endmodule

// ===== hw/rtl/wgm_back.sv =====
// Back end: mask element store, parallel NFA update and result register.
`timescale 1ns / 1ps

module wgm_back
   import wgm_pkg::*;
#(
   parameter int MASK_DEPTH = MASK_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  wgm_cmd_type         cmd,
   output logic                cmd_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output wgm_rsp_type         rsp_data,
   output wgm_back_status_type status
);

   localparam int LEN_W = $clog2(MASK_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_LIT,
      KIND_ANY,
      KIND_RUN
   } elem_kind_type;

   // element store, one lane per mask position
   elem_kind_type kind_ff [MASK_DEPTH];
   logic [7:0]    lit_ff  [MASK_DEPTH];

   logic [LEN_W-1:0]    len_ff, len_in;
   logic                esc_ff, esc_in;
   logic                ovf_ff, ovf_in;
   logic                last_run_ff, last_run_in;
   logic [MASK_DEPTH:0] raw_ff, raw_in;
   logic                rsp_valid_ff, rsp_valid_in;
   wgm_rsp_type         rsp_data_ff, rsp_data_in;

   logic [MASK_DEPTH-1:0] run_v;
   logic [MASK_DEPTH-1:0] step_v;
   logic [MASK_DEPTH:0]   closed_v;
   logic [MASK_DEPTH:0]   next_v;

   logic          exec;
   logic          mask_full;
   logic          store_req;
   logic          wr_en;
   elem_kind_type wr_kind;

   assign mask_full = (len_ff == LEN_W'(MASK_DEPTH));
   assign exec      = cmd_valid &&
                      ((cmd.action != ACT_REPORT) || !rsp_valid_ff || !rsp_stall);
   assign cmd_pop   = exec;

   // per-position lanes: run closure and one-byte step
   assign closed_v[0] = raw_ff[0];

   for (genvar p = 0; p < MASK_DEPTH; p++) begin : g_lane
      logic in_mask;
      assign in_mask   = (LEN_W'(p) < len_ff);
      assign run_v[p]  = in_mask && (kind_ff[p] == KIND_RUN);
      assign step_v[p] = in_mask && ((kind_ff[p] == KIND_ANY) ||
                         ((kind_ff[p] == KIND_LIT) && (lit_ff[p] == cmd.upper)));
      // consecutive runs are never stored, so one step of closure suffices
      assign closed_v[p+1] = raw_ff[p+1] | (raw_ff[p] & run_v[p]);

      always_ff @(posedge clock) begin
         if (wr_en && (len_ff == LEN_W'(p))) begin
            kind_ff[p] <= wr_kind;
            lit_ff[p]  <= cmd.upper;
         end
      end
   end

   assign next_v[0] = closed_v[0] & run_v[0];
   for (genvar q = 1; q <= MASK_DEPTH; q++) begin : g_next
      if (q < MASK_DEPTH) begin : g_mid
         assign next_v[q] = (closed_v[q] & run_v[q]) | (closed_v[q-1] & step_v[q-1]);
      end else begin : g_end
         assign next_v[q] = closed_v[q-1] & step_v[q-1];
      end
   end

   // mask loader: classify the appended byte into a store request
   always_comb begin
      store_req = 1'b0;
      wr_kind   = KIND_LIT;
      esc_in    = esc_ff;
      if (exec && (cmd.action == ACT_APPEND) && cmd.nonzero) begin
         if (esc_ff) begin
            esc_in    = 1'b0;
            store_req = 1'b1;
         end else begin
            case (cmd.cls)
               CLS_BSLASH: esc_in = 1'b1;
               CLS_STAR: begin
                  wr_kind   = KIND_RUN;
                  store_req = !((len_ff != '0) && last_run_ff);
               end
               CLS_QMARK: begin
                  wr_kind   = KIND_ANY;
                  store_req = 1'b1;
               end
               default: store_req = 1'b1;
            endcase
         end
      end else if (exec && (cmd.action == ACT_CLEAR)) begin
         esc_in = 1'b0;
      end
   end

   assign wr_en = store_req && !mask_full;

   always_comb begin
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      last_run_in  = last_run_ff;
      raw_in       = raw_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (exec) begin
         case (cmd.action)
            ACT_CLEAR: begin
               len_in      = '0;
               ovf_in      = 1'b0;
               last_run_in = 1'b0;
               raw_in      = (MASK_DEPTH + 1)'(1);
            end
            ACT_APPEND: begin
               if (cmd.nonzero) begin
                  raw_in = (MASK_DEPTH + 1)'(1);
               end
               if (wr_en) begin
                  len_in      = len_ff + LEN_W'(1);
                  last_run_in = (wr_kind == KIND_RUN);
               end else if (store_req) begin
                  ovf_in = 1'b1;
               end
            end
            ACT_SUBJECT: begin
               if (cmd.nonzero) begin
                  raw_in = next_v;
               end
            end
            default: begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.matched       = closed_v[len_ff] && !esc_ff && !ovf_ff;
               rsp_data_in.mask_overflow = ovf_ff;
               raw_in                    = (MASK_DEPTH + 1)'(1);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         esc_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         last_run_ff  <= 1'b0;
         raw_ff       <= (MASK_DEPTH + 1)'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         esc_ff       <= esc_in;
         ovf_ff       <= ovf_in;
         last_run_ff  <= last_run_in;
         raw_ff       <= raw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;
   assign status.mask_full = mask_full;
   assign status.overflow  = ovf_ff;

endmodule

// ===== hw/rtl/wildcard_glob_matcher.sv =====
// Top level: case-insensitive wildcard matcher with streamed subject bytes.
// rsp_valid comes from a register in the back end; a report passes the queue before it executes.
// The engine takes one transaction per cycle while it is not held.
// Only a report waiting on a stalled result register holds the engine; the queue absorbs that.
// Reset (synchronous, active high) empties the queue and the mask, clears the flags
// and leaves only the start position active; mask element contents stay undefined.
`timescale 1ns / 1ps

`include "wildcard_glob_matcher_assert.svh"

module wildcard_glob_matcher
   import wgm_pkg::*;
#(
   parameter int MASK_DEPTH  = MASK_DEPTH_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  wgm_req_type req_data,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output wgm_rsp_type rsp_data
);

   wgm_cmd_type          front_cmd;
   wgm_cmd_type          head_cmd;
   wgm_queue_status_type q_status;
   wgm_back_status_type  back_status;
   logic                 push;
   logic                 pop;

   // Classify the incoming transaction: fold case, flag special mask bytes.
   wgm_front u_front (
      .req (req_data),
      .cmd (front_cmd)
   );

   // Hold the request off only while the queue is full.
   assign req_stall = q_status.full;
   assign push      = req_valid && !req_stall;

   // Decouple intake from the engine so a stalled response does not block intake
   // until the queue fills.
   wgm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (front_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   // Execute one command per cycle unless held: clear or load the mask, advance the NFA, or report.
   wgm_back #(
      .MASK_DEPTH (MASK_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_status.not_empty),
      .cmd       (head_cmd),
      .cmd_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .status    (back_status)
   );

   // An accepted transaction not drained the same cycle must leave the queue occupied.
   `WGM_ASSERT_NEXT(a_push_fills, clock, reset, push && !pop, q_status.not_empty)
   // Overflow is only ever raised once the element store is full.
   `WGM_ASSERT_NOW(a_ovf_full, clock, reset, back_status.overflow, back_status.mask_full)
   // A reported overflow always comes with no match.
   `WGM_ASSERT_NOW(a_ovf_nomatch, clock, reset, rsp_valid && rsp_data.mask_overflow,
      !rsp_data.matched)

endmodule
